@@ hw/rtl/nns_pkg.sv @@
// nns_pkg: shared constants and types of the nearest-neighbor scaler
// used by nns_frame_mem and nearest_neighbor_scaler_rb_swap_top
// no dependencies
package nns_pkg;

  localparam int unsigned SRC_WIDTH_DEF  = 640;
  localparam int unsigned SRC_HEIGHT_DEF = 400;
  localparam int unsigned PIX_W          = 24;

  localparam logic [12:0] DEST_WIDTH_RST     = 13'd640;
  localparam logic [12:0] DEST_HEIGHT_RST    = 13'd400;
  localparam logic [13:0] DEST_ROW_PITCH_RST = 14'd640;

  localparam logic [7:0] ALPHA_ONES = 8'hFF;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef enum logic [1:0] {
    REG_DEST_WIDTH     = 2'd0,
    REG_DEST_HEIGHT    = 2'd1,
    REG_DEST_ROW_PITCH = 2'd2
  } cfg_reg_t;

  // item fields that ride alongside the divider stages
  typedef struct packed {
    logic              op;
    logic [17:0]       laddr;
    logic [PIX_W-1:0]  lpix;
    logic              err;
    logic [24:0]       daddr;
  } nns_side_t;

endpackage

@@ hw/rtl/nns_div.sv @@
// nns_div: pipelined restoring divider, one quotient bit per stage
// quotient must be known to fit in QW bits; no package dependency
module nns_div #(
  parameter int unsigned NUM_W = 25,
  parameter int unsigned QW    = 10
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] dividend,
  input  logic [12:0]      divisor,
  output logic [QW-1:0]    quotient
);

  localparam int unsigned CW = (NUM_W > 13 + QW) ? NUM_W : 13 + QW;

  logic [CW-1:0] rem [QW];
  logic [QW-1:0] quo [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [CW-1:0] rem_in;
    logic [CW-1:0] rem_next;
    logic [CW-1:0] dsh;
    logic [QW-1:0] quo_in;
    logic [QW-1:0] quo_next;

    if (i == 0) begin : g_first
      assign rem_in = CW'(dividend);
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem[i-1];
      assign quo_in = quo[i-1];
    end

    // divisor aligned to the quotient bit decided here
    assign dsh = CW'(divisor) << (QW - 1 - i);

    always_comb begin
      rem_next = rem_in;
      quo_next = quo_in;
      if (rem_in >= dsh) begin
        rem_next = rem_in - dsh;
        quo_next[QW-1-i] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= rem_next;
        quo[i] <= quo_next;
      end
    end
  end

  assign quotient = quo[QW-1];

endmodule

@@ hw/rtl/nns_frame_mem.sv @@
// nns_frame_mem: single-port source frame store, registered read
// depends on nns_pkg for the pixel width
module nns_frame_mem
  import nns_pkg::*;
#(
  parameter int unsigned DEPTH = 256000,
  parameter int unsigned AW    = 18
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [PIX_W-1:0] wdata,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

@@ hw/rtl/nearest_neighbor_scaler_rb_swap_top.sv @@
// nearest_neighbor_scaler_rb_swap_top: nearest-neighbor scaler with red/blue swap
// slave stream takes loads and fetches, master stream gives one result per fetch.
// tdata of a load writes one source pixel; tdata of a fetch names a destination
// pixel, mapped to source column x*SRC_WIDTH/dest_width, row y*SRC_HEIGHT/dest_height.
// results carry the pixel as 0xFFBBGGRR and the address y*dest_row_pitch+x.
// throughput: one item per cycle unless a held result stalls; loads and fetches share one pipeline.
// a fetch passes stage a, the QW divider stages, the frame store read register and
// the output register before it shows on m_tvalid; QW is the larger bit count of
// the source dimensions.
// a load writes the frame store at the stage where fetches read it, so every
// fetch sees exactly the loads transferred before it.
// the config channel is always ready; the user must write it only while the block is idle (not enforced).
// reset clears the valid bits and restores the config registers; the frame
// store is not cleared and holds garbage until loaded.
// when m_tready is low with a result held, the whole pipeline freezes and
// s_tready drops in the same cycle.
// depends on nns_pkg, nns_div, nns_frame_mem
module nearest_neighbor_scaler_rb_swap_top
  import nns_pkg::*;
#(
  parameter int unsigned SRC_WIDTH  = SRC_WIDTH_DEF,
  parameter int unsigned SRC_HEIGHT = SRC_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // load_address[17:0], load_pixel[41:18], fetch_x[61:50], fetch_y[73:62], zero
  input  logic [79:0] s_tdata,
  // opcode[0]
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_pixel[31:0], out_address[56:32], zero
  output logic [63:0] m_tdata,
  // range_error[0]
  output logic [0:0]  m_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  localparam int unsigned DEPTH = SRC_WIDTH * SRC_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SMAX  = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
  localparam int unsigned NUM_W = 12 + $clog2(SMAX + 1);
  localparam int unsigned QWX   = $clog2(SRC_WIDTH);
  localparam int unsigned QWY   = $clog2(SRC_HEIGHT);
  localparam int unsigned QXY   = (QWX > QWY) ? QWX : QWY;
  localparam int unsigned QW    = (QXY > 1) ? QXY : 1;

  // config registers
  logic [12:0] dest_width;
  logic [12:0] dest_height;
  logic [13:0] dest_row_pitch;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_width     <= DEST_WIDTH_RST;
      dest_height    <= DEST_HEIGHT_RST;
      dest_row_pitch <= DEST_ROW_PITCH_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEST_WIDTH:     dest_width     <= cfg_data[12:0];
        REG_DEST_HEIGHT:    dest_height    <= cfg_data[12:0];
        REG_DEST_ROW_PITCH: dest_row_pitch <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: stall only while a held result is not taken
  logic en;
  logic out_valid;

  assign en       = !out_valid || m_tready;
  assign s_tready = en;

  // input unpack
  logic              in_op;
  logic [17:0]       in_laddr;
  logic [PIX_W-1:0]  in_lpix;
  logic [11:0]       in_x;
  logic [11:0]       in_y;
  logic [25:0]       in_yp_full;
  logic [NUM_W-1:0]  in_numx;
  logic [NUM_W-1:0]  in_numy;

  assign in_op      = s_tuser[0];
  assign in_laddr   = s_tdata[17:0];
  assign in_lpix    = s_tdata[41:18];
  assign in_x       = s_tdata[61:50];
  assign in_y       = s_tdata[73:62];
  assign in_yp_full = in_y * dest_row_pitch;
  assign in_numx    = NUM_W'(32'(in_x) * 32'(SRC_WIDTH));
  assign in_numy    = NUM_W'(32'(in_y) * 32'(SRC_HEIGHT));

  // stage a: products and range check
  logic              a_valid;
  logic              a_op;
  logic [17:0]       a_laddr;
  logic [PIX_W-1:0]  a_lpix;
  logic [11:0]       a_x;
  logic [24:0]       a_yp;
  logic              a_err;
  logic [NUM_W-1:0]  a_numx;
  logic [NUM_W-1:0]  a_numy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op    <= in_op;
      a_laddr <= in_laddr;
      a_lpix  <= in_lpix;
      a_x     <= in_x;
      a_yp    <= in_yp_full[24:0];
      a_err   <= ({1'b0, in_x} >= dest_width) || ({1'b0, in_y} >= dest_height);
      a_numx  <= in_numx;
      a_numy  <= in_numy;
    end
  end

  // dividers
  logic [QW-1:0] qx;
  logic [QW-1:0] qy;

  nns_div #(
    .NUM_W (NUM_W),
    .QW    (QW)
  ) u_div_x (
    .clk      (clk),
    .en       (en),
    .dividend (a_numx),
    .divisor  (dest_width),
    .quotient (qx)
  );

  nns_div #(
    .NUM_W (NUM_W),
    .QW    (QW)
  ) u_div_y (
    .clk      (clk),
    .en       (en),
    .dividend (a_numy),
    .divisor  (dest_height),
    .quotient (qy)
  );

  // side line in step with the divider stages
  nns_side_t a_side;
  logic      ln_valid [QW];
  nns_side_t ln_side  [QW];

  always_comb begin
    a_side.op    = a_op;
    a_side.laddr = a_laddr;
    a_side.lpix  = a_lpix;
    a_side.err   = a_err;
    a_side.daddr = a_yp + 25'(a_x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QW; i++) begin
        ln_valid[i] <= 1'b0;
      end
    end else if (en) begin
      for (int i = QW - 1; i > 0; i--) begin
        ln_valid[i] <= ln_valid[i-1];
      end
      ln_valid[0] <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = QW - 1; i > 0; i--) begin
        ln_side[i] <= ln_side[i-1];
      end
      ln_side[0] <= a_side;
    end
  end

  // frame store access: loads write and fetches read at this one stage
  nns_side_t         last;
  logic              last_valid;
  logic [31:0]       laddr32;
  logic [31:0]       faddr32;
  logic              load_hit;
  logic [AW-1:0]     mem_addr;
  logic [PIX_W-1:0]  rd_pix;

  assign last       = ln_side[QW-1];
  assign last_valid = ln_valid[QW-1];
  assign laddr32    = {14'd0, last.laddr};
  assign faddr32    = 32'(qy) * 32'(SRC_WIDTH) + 32'(qx);
  assign load_hit   = last_valid && (last.op == OP_LOAD) && (laddr32 < 32'(DEPTH));
  assign mem_addr   = (last.op == OP_LOAD) ? laddr32[AW-1:0] : faddr32[AW-1:0];

  nns_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame_mem (
    .clk   (clk),
    .en    (en),
    .we    (load_hit),
    .addr  (mem_addr),
    .wdata (last.lpix),
    .rdata (rd_pix)
  );

  logic        mm_valid;
  logic        mm_fetch;
  logic        mm_err;
  logic [24:0] mm_daddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      mm_valid <= 1'b0;
    end else if (en) begin
      mm_valid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mm_fetch <= (last.op == OP_FETCH);
      mm_err   <= last.err;
      mm_daddr <= last.daddr;
    end
  end

  // output register
  logic [31:0] out_pix;
  logic [24:0] out_addr;
  logic        out_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= mm_valid && mm_fetch;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_err <= mm_err;
      if (mm_err) begin
        out_pix  <= '0;
        out_addr <= '0;
      end else begin
        // red and blue swap places
        out_pix  <= {ALPHA_ONES, rd_pix[7:0], rd_pix[15:8], rd_pix[23:16]};
        out_addr <= mm_daddr;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_addr, out_pix};
  assign m_tuser  = out_err;

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("range error result carries nonzero data");

  a_alpha_ones: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[31:24] == ALPHA_ONES)
    else $error("pixel result lacks forced alpha");

  a_fetch_out: assert property (@(posedge clk) disable iff (rst)
    en && mm_valid && mm_fetch |=> m_tvalid)
    else $error("fetch leaving the store stage produced no result");

  a_load_no_out: assert property (@(posedge clk) disable iff (rst)
    en && !(mm_valid && mm_fetch) |=> !m_tvalid)
    else $error("result appeared without a fetch");
`endif

endmodule
